// ===== src/midpoint_circle_generator_macros.svh =====
// ============================================================================
// Midpoint circle generator assertion macros
// Shared assertion wrappers for the checker of the circle generator.
// ============================================================================
`ifndef MIDPOINT_CIRCLE_GENERATOR_MACROS_SVH
`define MIDPOINT_CIRCLE_GENERATOR_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted.
`define MCG_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Property checked on every rising edge, reset included.
`define MCG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mcg_pkg.sv =====
// ============================================================================
// Midpoint circle generator package
// Fixed widths, command kinds and control encodings shared by the modules.
// ============================================================================
package mcg_pkg;

    // Width of an emitted point coordinate (two's complement).
    localparam int PT_BITS    = 14;
    // Width of the carried RGB color.
    localparam int COLOR_BITS = 24;
    // Width of the stored midpoint error term.
    localparam int ERR_BITS   = 16;

    // Command kinds carried on the input channel.
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } back_state_t;

    // Position of a pixel among the eight mirrored points of one step.
    typedef enum logic [2:0] {
        PIX_0 = 3'd0,
        PIX_1 = 3'd1,
        PIX_2 = 3'd2,
        PIX_3 = 3'd3,
        PIX_4 = 3'd4,
        PIX_5 = 3'd5,
        PIX_6 = 3'd6,
        PIX_7 = 3'd7
    } pix_t;

endpackage

// ===== src/midpoint_circle_generator.sv =====
// ============================================================================
// Midpoint circle generator
// Path: a step passes the front holding register, the queue and the sequencer
// state before its first pixel leaves the output register. Throughput: one pixel
// per cycle unless m_ready stalls, set by the output register; a start emits none.
// Reset: synchronous active-low aresetn empties the queue, clears all valid
// flags and leaves no circle active.
// ============================================================================
module midpoint_circle_generator import mcg_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [COORD_BITS-1:0]     s_center_x,
    input  logic [COORD_BITS-1:0]     s_center_y,
    input  logic [COORD_BITS-2:0]     s_radius,
    input  logic [COLOR_BITS-1:0]     s_pixel_color,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [PT_BITS-1:0] m_point_x,
    output logic signed [PT_BITS-1:0] m_point_y,
    output logic [COLOR_BITS-1:0]     m_point_color,
    output logic                      m_last_of_step,
    output logic                      m_circle_done
);

    localparam int ITEM_BITS = 3 * COORD_BITS + COLOR_BITS;

    logic                 fq_valid;
    logic                 fq_ready;
    logic [ITEM_BITS-1:0] fq_data;
    logic                 qb_valid;
    logic                 qb_ready;
    logic [ITEM_BITS-1:0] qb_data;

    // Command intake and decode.
    mcg_front #(
        .COORD_BITS (COORD_BITS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_center_x    (s_center_x),
        .s_center_y    (s_center_y),
        .s_radius      (s_radius),
        .s_pixel_color (s_pixel_color),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    // Command queue between front and back.
    mcg_queue #(
        .DATA_BITS (ITEM_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // Circle state and pixel emission.
    mcg_back #(
        .COORD_BITS (COORD_BITS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_data         (qb_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_point_color  (m_point_color),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

endmodule

// ===== src/mcg_front.sv =====
// ============================================================================
// Midpoint circle generator front end
// Registers incoming commands, decodes the command kind and packs each item
// for the command queue.
// ============================================================================
module mcg_front import mcg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int ITEM_BITS  = 3 * COORD_BITS + COLOR_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [COORD_BITS-1:0] s_center_x,
    input  logic [COORD_BITS-1:0] s_center_y,
    input  logic [COORD_BITS-2:0] s_radius,
    input  logic [COLOR_BITS-1:0] s_pixel_color,
    output logic                  q_valid,
    input  logic                  q_ready,
    output logic [ITEM_BITS-1:0]  q_data
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [ITEM_BITS-1:0] item_reg;
    cmd_t                 kind;

    // Decode the command kind.
    assign kind = s_cmd ? CMD_STEP : CMD_START;

    // The holding register frees up whenever the queue takes its item.
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Pack kind, center, radius and color into one queue item.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= {kind, s_center_x, s_center_y, s_radius, s_pixel_color};
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = item_reg;

endmodule

// ===== src/mcg_queue.sv =====
// ============================================================================
// Midpoint circle generator command queue
// Two-entry queue that decouples the front end from the back end.
// ============================================================================
module mcg_queue import mcg_pkg::*; #(
    parameter int DATA_BITS = 60
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic [DATA_BITS-1:0] head_reg;
    logic [DATA_BITS-1:0] tail_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Occupancy count.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Head always holds the oldest entry; the tail slot moves up on a pop.
    always_ff @(posedge aclk) begin
        case (count_reg)
            2'd0: begin
                if (push) begin
                    head_reg <= in_data;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    head_reg <= in_data;
                end else if (push) begin
                    tail_reg <= in_data;
                end
            end
            default: begin
                if (pop) begin
                    head_reg <= tail_reg;
                end
            end
        endcase
    end

endmodule

// ===== src/mcg_back.sv =====
// ============================================================================
// Midpoint circle generator back end
// Holds the active circle, emits the eight mirrored pixels of each step
// through an output register and advances the midpoint error term.
// ============================================================================
module mcg_back import mcg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int ITEM_BITS  = 3 * COORD_BITS + COLOR_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  logic [ITEM_BITS-1:0]      q_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [PT_BITS-1:0] m_point_x,
    output logic signed [PT_BITS-1:0] m_point_y,
    output logic [COLOR_BITS-1:0]     m_point_color,
    output logic                      m_last_of_step,
    output logic                      m_circle_done
);

    localparam int CW = COORD_BITS;
    // Error arithmetic width: holds the stored error plus 2*y + 1 and 2*x.
    localparam int EW = (COORD_BITS > 14) ? COORD_BITS + 4 : 18;

    // Unpacked queue item.
    cmd_t                  q_kind;
    logic [CW-1:0]         q_cx;
    logic [CW-1:0]         q_cy;
    logic [CW-2:0]         q_radius;
    logic [COLOR_BITS-1:0] q_color;

    // Circle state.
    logic [CW-1:0]               ctr_x_reg;
    logic [CW-1:0]               ctr_y_reg;
    logic signed [CW:0]          oct_x_reg;
    logic [CW-1:0]               oct_y_reg;
    logic signed [ERR_BITS-1:0]  mid_err_reg;
    logic [COLOR_BITS-1:0]       held_color_reg;
    logic                        busy_reg;

    // Sequencer.
    back_state_t state_reg;
    back_state_t state_next;
    pix_t        idx_reg;
    pix_t        idx_next;

    // Output register.
    logic                      m_valid_reg;
    logic signed [PT_BITS-1:0] point_x_reg;
    logic signed [PT_BITS-1:0] point_y_reg;
    logic [COLOR_BITS-1:0]     point_color_reg;
    logic                      last_reg;
    logic                      done_reg;

    // Handshake and advance signals.
    logic                 out_load;
    logic                 emit_last;
    logic                 pop;
    logic                 busy_eff;
    logic [CW-1:0]        y_new;
    logic signed [EW-1:0] err_ext;
    logic signed [EW-1:0] inc_y;
    logic signed [EW-1:0] x_ext;
    logic signed [EW-1:0] err_a;
    logic signed [EW-1:0] err_b;
    logic                 step_x;
    logic signed [CW:0]   x_new;
    logic signed [EW-1:0] err_new;
    logic                 done_c;

    // Point arithmetic, all modulo 2^PT_BITS.
    logic [PT_BITS-1:0] cx_p;
    logic [PT_BITS-1:0] cy_p;
    logic [PT_BITS-1:0] x_p;
    logic [PT_BITS-1:0] y_p;
    logic [PT_BITS-1:0] px;
    logic [PT_BITS-1:0] py;

    assign q_kind   = cmd_t'(q_data[ITEM_BITS-1]);
    assign q_cx     = q_data[COLOR_BITS + 2*CW - 1 +: CW];
    assign q_cy     = q_data[COLOR_BITS + CW - 1 +: CW];
    assign q_radius = q_data[COLOR_BITS +: CW-1];
    assign q_color  = q_data[COLOR_BITS-1:0];

    // The output register takes a pixel when it is empty or being drained.
    assign out_load  = !m_valid_reg || m_ready;
    assign emit_last = (state_reg == ST_EMIT) && out_load && (idx_reg == PIX_7);
    assign q_ready   = (state_reg == ST_IDLE) || emit_last;
    assign pop       = q_valid && q_ready;

    // Midpoint advance: y up by one, then x down when err + 2*y + 1 - x >= 0.
    assign y_new   = oct_y_reg + CW'(1);
    assign err_ext = EW'(mid_err_reg);
    assign inc_y   = EW'($signed({2'b00, y_new, 1'b1}));
    assign x_ext   = EW'(oct_x_reg);
    assign err_a   = err_ext + inc_y;
    assign step_x  = (err_a >= x_ext);
    assign err_b   = err_a - x_ext - x_ext + EW'(3);
    assign x_new   = step_x ? (oct_x_reg - (CW+1)'(1)) : oct_x_reg;
    assign err_new = step_x ? err_b : err_a;
    assign done_c  = (x_new < $signed({1'b0, y_new}));

    // A step popped in the same cycle as the final pixel sees the new busy.
    assign busy_eff = emit_last ? !done_c : busy_reg;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if ((state_reg == ST_EMIT) && out_load) begin
            idx_next = pix_t'(idx_reg + 3'd1);
        end
        if (pop) begin
            idx_next = PIX_0;
            if ((q_kind == CMD_STEP) && busy_eff) begin
                state_next = ST_EMIT;
            end else begin
                state_next = ST_IDLE;
            end
        end else if (emit_last) begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= PIX_0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Circle state: a start overrides the advance of a finishing step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (pop && (q_kind == CMD_START)) begin
            busy_reg <= 1'b1;
        end else if (emit_last) begin
            busy_reg <= !done_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && (q_kind == CMD_START)) begin
            ctr_x_reg      <= q_cx;
            ctr_y_reg      <= q_cy;
            oct_x_reg      <= $signed({2'b00, q_radius});
            oct_y_reg      <= '0;
            mid_err_reg    <= '0;
            held_color_reg <= q_color;
        end else if (emit_last) begin
            oct_x_reg   <= x_new;
            oct_y_reg   <= y_new;
            mid_err_reg <= ERR_BITS'(err_new);
        end
    end

    // Mirrored pixel selection.
    assign cx_p = PT_BITS'(ctr_x_reg);
    assign cy_p = PT_BITS'(ctr_y_reg);
    assign x_p  = PT_BITS'(oct_x_reg);
    assign y_p  = PT_BITS'(oct_y_reg);

    always_comb begin
        case (idx_reg)
            PIX_0: begin
                px = cx_p + x_p;
                py = cy_p + y_p;
            end
            PIX_1: begin
                px = cx_p + y_p;
                py = cy_p + x_p;
            end
            PIX_2: begin
                px = cx_p - y_p;
                py = cy_p + x_p;
            end
            PIX_3: begin
                px = cx_p - x_p;
                py = cy_p + y_p;
            end
            PIX_4: begin
                px = cx_p - x_p;
                py = cy_p - y_p;
            end
            PIX_5: begin
                px = cx_p - y_p;
                py = cy_p - x_p;
            end
            PIX_6: begin
                px = cx_p + y_p;
                py = cy_p - x_p;
            end
            default: begin
                px = cx_p + x_p;
                py = cy_p - y_p;
            end
        endcase
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_EMIT) && out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EMIT) && out_load) begin
            point_x_reg     <= $signed(px);
            point_y_reg     <= $signed(py);
            point_color_reg <= held_color_reg;
            last_reg        <= (idx_reg == PIX_7);
            done_reg        <= (idx_reg == PIX_7) && done_c;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point_x      = point_x_reg;
    assign m_point_y      = point_y_reg;
    assign m_point_color  = point_color_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

endmodule

// ===== src/mcg_checker.sv =====
// ============================================================================
// Midpoint circle generator port checker
// Watches the ports of the generator and checks step framing and reset.
// ============================================================================
`include "midpoint_circle_generator_macros.svh"

module mcg_checker import mcg_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [PT_BITS-1:0] m_point_x,
    input logic signed [PT_BITS-1:0] m_point_y,
    input logic [COLOR_BITS-1:0]     m_point_color,
    input logic                      m_last_of_step,
    input logic                      m_circle_done
);

    pix_t                          pix_cnt_reg;
    logic                          out_xfer;
    logic [2*PT_BITS+COLOR_BITS+1:0] m_payload;

    assign out_xfer  = m_valid && m_ready;
    assign m_payload = {m_point_x, m_point_y, m_point_color, m_last_of_step, m_circle_done};

    // Count result transfers within the current step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg <= PIX_0;
        end else if (out_xfer) begin
            pix_cnt_reg <= m_last_of_step ? PIX_0 : pix_t'(pix_cnt_reg + 3'd1);
        end
    end

    // A stalled result keeps its valid and its whole payload.
    property p_stall_hold;
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload));
    endproperty

    property p_done_on_last;
        (m_valid && m_circle_done) |-> m_last_of_step;
    endproperty

    property p_last_at_eighth;
        (m_valid && m_last_of_step) |-> (pix_cnt_reg == PIX_7);
    endproperty

    property p_eighth_is_last;
        (m_valid && (pix_cnt_reg == PIX_7)) |-> m_last_of_step;
    endproperty

    `MCG_ASSERT(a_stall_hold, aclk, aresetn, p_stall_hold, "result changed while stalled")
    `MCG_ASSERT(a_done_on_last, aclk, aresetn, p_done_on_last, "circle_done without last")
    `MCG_ASSERT(a_last_at_eighth, aclk, aresetn, p_last_at_eighth, "last not on eighth pixel")
    `MCG_ASSERT(a_eighth_is_last, aclk, aresetn, p_eighth_is_last, "eighth pixel not last")
    `MCG_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind midpoint_circle_generator mcg_checker u_mcg_checker (.*);
